[design/c3sr_pkg.sv]
// shared constants, codes and types of the 3x3 convolution block
package c3sr_pkg;

  // default sizing of the stores
  localparam int DEF_MAX_SIZE     = 32;
  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_MAX_FILTERS  = 16;

  // kernel geometry
  localparam int KSIZE = 3;
  localparam int KTAPS = KSIZE * KSIZE;
  localparam logic [1:0] TAP_LAST = 2'(KSIZE - 1);

  // field widths
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 13;
  localparam int VALUE_W  = 16;
  localparam int FILTER_W = 4;
  localparam int COORD_W  = 5;
  localparam int RESULT_W = 15;

  // fixed point
  localparam int FRAC_BITS = 8;
  localparam logic [RESULT_W-1:0] RESULT_MAX = {RESULT_W{1'b1}};

  // register file
  localparam int FC_W    = 5;
  localparam int IS_W    = 6;
  localparam int CC_W    = 4;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [FC_W-1:0] FC_RESET = 5'd1;
  localparam logic [IS_W-1:0] IS_RESET = 6'd28;
  localparam logic [CC_W-1:0] CC_RESET = 4'd1;

  typedef enum logic [1:0] {
    REG_FILTER_COUNT,
    REG_IMAGE_SIZE,
    REG_CHANNEL_COUNT
  } reg_index_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_WEIGHT,
    OP_LOAD_BIAS,
    OP_LOAD_PIXEL,
    OP_COMPUTE
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // sequencer to multiply-accumulate unit
  typedef struct packed {
    logic init;       // load accumulator with the scaled bias
    logic tap_valid;  // a tap is presented this cycle
    logic tap_used;   // the tap lies inside the image
  } mac_ctrl_t;

endpackage

[design/c3sr_mac.sv]
// shared multiply-accumulate unit: registered product, then wide accumulate
module c3sr_mac #(
  parameter int ACC_W = 41
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  c3sr_pkg::mac_ctrl_t                   ctrl,
  input  logic signed [c3sr_pkg::VALUE_W-1:0]   weight,
  input  logic signed [c3sr_pkg::VALUE_W-1:0]   pixel,
  input  logic signed [c3sr_pkg::VALUE_W-1:0]   bias,
  output logic signed [ACC_W-1:0]               acc
);
  import c3sr_pkg::*;

  localparam int PROD_W = 2 * VALUE_W;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.tap_valid;
    end
  end

  always_ff @(posedge clk) begin
    // taps in the padding contribute nothing
    if (ctrl.tap_used) begin
      prod <= weight * pixel;
    end else begin
      prod <= '0;
    end
    if (ctrl.init) begin
      acc <= ACC_W'(bias) <<< FRAC_BITS;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

[design/conv3x3_same_relu.sv]
// top level: stores, tap sequencer and output register of the 3x3 convolution
//
//  port group      direction  beat contents
//  item_*          in         op, address, sample_value, out_filter, out_row, out_col
//  result_*        out        result_value (relu output, q7.8)
//  apb (p*)        in/out     filter_count, image_size, channel_count
//
// a load beat writes its store at the accepting edge
// a compute beat is paced by the single multiply-accumulate unit, which
//   walks every tap behind the registered store reads
// an output outside the configured range returns 0 without a tap walk
// reset restores the registers (1, 28, 1); stores are not cleared
// a finished result waits in the output register; a later compute stalls
//   in its last cycle until that beat has been taken
module conv3x3_same_relu #(
  parameter int MAX_SIZE     = c3sr_pkg::DEF_MAX_SIZE,
  parameter int MAX_CHANNELS = c3sr_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_FILTERS  = c3sr_pkg::DEF_MAX_FILTERS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input items
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic [c3sr_pkg::OP_W-1:0]            op,
  input  logic [c3sr_pkg::ADDR_W-1:0]          address,
  input  logic signed [c3sr_pkg::VALUE_W-1:0]  sample_value,
  input  logic [c3sr_pkg::FILTER_W-1:0]        out_filter,
  input  logic [c3sr_pkg::COORD_W-1:0]         out_row,
  input  logic [c3sr_pkg::COORD_W-1:0]         out_col,
  // results
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic [c3sr_pkg::RESULT_W-1:0]        result_value,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [c3sr_pkg::PADDR_W-1:0]         paddr,
  input  logic [c3sr_pkg::PDATA_W-1:0]         pwdata,
  output logic [c3sr_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);
  import c3sr_pkg::*;

  // store geometry
  localparam int WDEPTH = MAX_FILTERS * MAX_CHANNELS * KTAPS;
  localparam int PDEPTH = MAX_CHANNELS * MAX_SIZE * MAX_SIZE;
  localparam int WIDX_W = $clog2(WDEPTH);
  localparam int PIDX_W = $clog2(PDEPTH);
  localparam int BIDX_W = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  // effective register widths
  localparam int NF_W = $clog2(MAX_FILTERS + 1);
  localparam int SZ_W = $clog2(MAX_SIZE + 1);
  localparam int NC_W = $clog2(MAX_CHANNELS + 1);
  // exact sum of all products plus the scaled bias
  localparam int ACC_W = 2 * VALUE_W + $clog2(KTAPS * MAX_CHANNELS + 1) + 1;

  // configuration registers
  logic [FC_W-1:0] filter_count;
  logic [IS_W-1:0] image_size;
  logic [CC_W-1:0] channel_count;

  // clamped register values
  logic [NF_W-1:0] nf;
  logic [SZ_W-1:0] sz;
  logic [NC_W-1:0] nc;

  // stores
  logic signed [VALUE_W-1:0] wmem [WDEPTH];
  logic signed [VALUE_W-1:0] bmem [MAX_FILTERS];
  logic signed [VALUE_W-1:0] pmem [PDEPTH];

  // sequencer
  state_t state, state_next;
  logic                item_accept;
  logic                in_range;
  logic [FILTER_W-1:0] f_sel;
  logic [COORD_W-1:0]  row_sel;
  logic [COORD_W-1:0]  col_sel;
  logic                zero_out;
  logic [WIDX_W-1:0]   wptr;
  logic [PIDX_W-1:0]   pptr;
  logic [PIDX_W-1:0]   step_row;
  logic [PIDX_W-1:0]   step_ch;
  logic [1:0]          kc;
  logic [1:0]          kr;
  logic [NC_W-1:0]     ch;
  logic                drain;
  logic [COORD_W:0]    r_pad;
  logic [COORD_W:0]    k_pad;
  logic                tap_ok;
  logic                last_tap;

  // read data and tap flags, held in the cycle after the pointers
  logic signed [VALUE_W-1:0] w_q;
  logic signed [VALUE_W-1:0] p_q;
  logic signed [VALUE_W-1:0] bias_q;
  logic                      tap_ok_q;
  logic                      issued_q;

  mac_ctrl_t               mac_ctrl;
  logic signed [ACC_W-1:0] acc;
  logic [RESULT_W-1:0]     result_calc;
  logic                    result_load;

  // ---------------------------------------------------------------------
  // configuration port, writes complete in the access phase
  // ---------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_count  <= FC_RESET;
      image_size    <= IS_RESET;
      channel_count <= CC_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[PADDR_W-1:2])
        REG_FILTER_COUNT:  filter_count  <= pwdata[FC_W-1:0];
        REG_IMAGE_SIZE:    image_size    <= pwdata[IS_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= pwdata[CC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_FILTER_COUNT:  prdata = PDATA_W'(filter_count);
      REG_IMAGE_SIZE:    prdata = PDATA_W'(image_size);
      REG_CHANNEL_COUNT: prdata = PDATA_W'(channel_count);
      default:           prdata = '0;
    endcase
  end

  // zero acts as one, anything above the store size acts as the maximum
  always_comb begin
    if (filter_count == '0) begin
      nf = NF_W'(1);
    end else if (int'(filter_count) > MAX_FILTERS) begin
      nf = NF_W'(MAX_FILTERS);
    end else begin
      nf = NF_W'(filter_count);
    end
    if (image_size == '0) begin
      sz = SZ_W'(1);
    end else if (int'(image_size) > MAX_SIZE) begin
      sz = SZ_W'(MAX_SIZE);
    end else begin
      sz = SZ_W'(image_size);
    end
    if (channel_count == '0) begin
      nc = NC_W'(1);
    end else if (int'(channel_count) > MAX_CHANNELS) begin
      nc = NC_W'(MAX_CHANNELS);
    end else begin
      nc = NC_W'(channel_count);
    end
  end

  // ---------------------------------------------------------------------
  // input handshake and sequencer
  // ---------------------------------------------------------------------
  assign item_ready  = (state == ST_IDLE);
  assign item_accept = item_valid && item_ready;

  assign in_range = (int'(out_filter) < int'(nf)) && (int'(out_row) < int'(sz))
                    && (int'(out_col) < int'(sz));

  // padded coordinates of the current tap, one pixel of zero border
  assign r_pad  = (COORD_W + 1)'(row_sel) + (COORD_W + 1)'(kr);
  assign k_pad  = (COORD_W + 1)'(col_sel) + (COORD_W + 1)'(kc);
  assign tap_ok = (r_pad != '0) && (k_pad != '0) && (int'(r_pad) <= int'(sz))
                  && (int'(k_pad) <= int'(sz));

  assign last_tap = (kc == TAP_LAST) && (kr == TAP_LAST) && (int'(ch) == int'(nc) - 1);

  // results leave through the output register; wait while it is occupied
  assign result_load = (state == ST_FINISH) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    mac_ctrl.init      = 1'b0;
    mac_ctrl.tap_valid = issued_q;
    mac_ctrl.tap_used  = tap_ok_q;
    case (state)
      ST_IDLE: begin
        if (item_accept && (op == OP_COMPUTE)) begin
          state_next = in_range ? ST_SETUP : ST_FINISH;
        end
      end
      ST_SETUP: begin
        mac_ctrl.init = 1'b1;
        state_next    = ST_RUN;
      end
      ST_RUN: begin
        if (last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // read and product stages still hold the final taps
        if (drain) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (result_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // tap walk: weights are contiguous per filter; the pixel pointer steps
  // along a row, down to the next row, then on to the next channel plane
  always_ff @(posedge clk) begin
    if (item_accept) begin
      f_sel    <= out_filter;
      row_sel  <= out_row;
      col_sel  <= out_col;
      zero_out <= !in_range;
    end
    if (state == ST_SETUP) begin
      wptr     <= WIDX_W'(f_sel) * WIDX_W'(nc) * WIDX_W'(KTAPS);
      pptr     <= PIDX_W'(row_sel) * PIDX_W'(sz) - PIDX_W'(sz) + PIDX_W'(col_sel)
                  - PIDX_W'(1);
      step_row <= PIDX_W'(sz) - PIDX_W'(2);
      step_ch  <= PIDX_W'(sz) * PIDX_W'(sz) - PIDX_W'(2) * PIDX_W'(sz) - PIDX_W'(2);
      kc       <= '0;
      kr       <= '0;
      ch       <= '0;
      drain    <= 1'b0;
    end else if (state == ST_RUN) begin
      wptr <= wptr + WIDX_W'(1);
      if (kc == TAP_LAST) begin
        kc <= '0;
        if (kr == TAP_LAST) begin
          kr   <= '0;
          ch   <= ch + NC_W'(1);
          pptr <= pptr + step_ch;
        end else begin
          kr   <= kr + 2'd1;
          pptr <= pptr + step_row;
        end
      end else begin
        kc   <= kc + 2'd1;
        pptr <= pptr + PIDX_W'(1);
      end
    end else if (state == ST_DRAIN) begin
      drain <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issued_q <= 1'b0;
    end else begin
      issued_q <= (state == ST_RUN);
    end
  end

  always_ff @(posedge clk) begin
    tap_ok_q <= tap_ok;
  end

  // ---------------------------------------------------------------------
  // stores: written by load beats, read with registered data
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (item_accept && (op == OP_LOAD_WEIGHT) && (int'(address) < WDEPTH)) begin
      wmem[WIDX_W'(address)] <= sample_value;
    end
    w_q <= wmem[wptr];
  end

  always_ff @(posedge clk) begin
    if (item_accept && (op == OP_LOAD_BIAS) && (int'(address) < MAX_FILTERS)) begin
      bmem[BIDX_W'(address)] <= sample_value;
    end
    // bias of the requested filter, ready for the setup cycle
    if (item_accept) begin
      bias_q <= bmem[BIDX_W'(out_filter)];
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept && (op == OP_LOAD_PIXEL) && (int'(address) < PDEPTH)) begin
      pmem[PIDX_W'(address)] <= sample_value;
    end
    // padding taps may point anywhere; their data is masked in the unit
    p_q <= pmem[pptr];
  end

  // ---------------------------------------------------------------------
  // shared multiply-accumulate
  // ---------------------------------------------------------------------
  c3sr_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .weight (w_q),
    .pixel  (p_q),
    .bias   (bias_q),
    .acc    (acc)
  );

  // ---------------------------------------------------------------------
  // relu, floor to q7.8 and saturation, then the output register
  // ---------------------------------------------------------------------
  always_comb begin
    if (zero_out || acc[ACC_W-1] || (acc == '0)) begin
      result_calc = '0;
    end else if (|acc[ACC_W-1:RESULT_W+FRAC_BITS]) begin
      result_calc = RESULT_MAX;
    end else begin
      result_calc = acc[RESULT_W+FRAC_BITS-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result_value <= result_calc;
    end
  end

endmodule
